// ===== src/lfdt_pkg.sv =====
// ----------------------------------------------------------------------------
// lfdt_pkg
// Shared sizes, operation codes and status codes of the lowest-free
// descriptor table.
// ----------------------------------------------------------------------------
package lfdt_pkg;

  // Table geometry
  localparam int SLOTS_PER_BUCKET = 64;
  localparam int BUCKET_COUNT     = 16;
  localparam int TOTAL_SLOTS      = SLOTS_PER_BUCKET * BUCKET_COUNT;

  // Fixed field widths
  localparam int OP_W  = 3;
  localparam int FDI_W = 12;
  localparam int FD_W  = 10;
  localparam int OBJ_W = 32;
  localparam int ST_W  = 2;

  // Derived widths
  localparam int IDX_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int BASE_W = IDX_W + 1;
  localparam int OFF_W  = $clog2(SLOTS_PER_BUCKET);
  localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int ROW_W  = FILL_W + SLOTS_PER_BUCKET;
  localparam int NGRP   = (SLOTS_PER_BUCKET + 7) / 8;
  localparam int SCN_W  = NGRP * 8;
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_CLOSE = 3'd1,
    OP_PUT   = 3'd2,
    OP_DUP2  = 3'd3,
    OP_GET   = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BADFD     = 2'd1,
    ST_NOFREE    = 2'd2,
    ST_NOTPLACED = 2'd3
  } status_e;

endpackage

// ===== src/lowest_free_descriptor_table.sv =====
// ----------------------------------------------------------------------------
// lowest_free_descriptor_table
// Descriptor table with per-bucket open bitmaps and fill counts; allocates
// the lowest free slot at or above a floor, and handles close/put/dup2/get.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | operation, target_fd, source_fd,
//          |           |                         | object_handle, writable_in
//  out     | output    | out_valid_o/out_ready_i | status, result_fd, held_*,
//          |           |                         | released_valid, released_handle
//
//  One word at a time. A slot index is split into bucket and offset by a
//  compare/add unit stepping one bucket per cycle; dup2 locates the source,
//  then the target. Allocate reads bucket rows upward from the floor's
//  bucket, skips full ones and searches the others' free bits in 8-slot groups.
//  in_ready_o is high only when idle; a finished result waits in the output
//  register without holding up input, and only a previous word still unread
//  there holds the sequencer in its last state.
//  Reset clears the row valid bits, so all slots read as closed.
// ----------------------------------------------------------------------------
module lowest_free_descriptor_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lfdt_pkg::OP_W-1:0]     operation_i,
  input  logic signed [lfdt_pkg::FDI_W-1:0] target_fd_i,
  input  logic signed [lfdt_pkg::FDI_W-1:0] source_fd_i,
  input  logic [lfdt_pkg::OBJ_W-1:0]    object_handle_i,
  input  logic                          writable_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lfdt_pkg::ST_W-1:0]     status_o,
  output logic [lfdt_pkg::FD_W-1:0]     result_fd_o,
  output logic [lfdt_pkg::OBJ_W-1:0]    held_handle_o,
  output logic                          held_writable_o,
  output logic                          released_valid_o,
  output logic [lfdt_pkg::OBJ_W-1:0]    released_handle_o
);
  import lfdt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_POS, S_RD, S_EV, S_SCAN, S_DONE
  } state_e;

  state_e state_q;

  // latched word
  logic [OP_W-1:0]         op_q;
  logic signed [FDI_W-1:0] tfd_q;
  logic signed [FDI_W-1:0] sfd_q;
  logic [OBJ_W-1:0]        obj_q;
  logic                    wr_q;

  // sequencer
  logic [IDX_W-1:0]  key_q;
  logic [BKT_W-1:0]  bkt_q;
  logic [BASE_W-1:0] base_q;
  logic              tgt_q;
  logic              first_q;
  logic [GRP_W-1:0]  grp_q;
  logic [SCN_W-1:0]  scan_q;
  logic [ROW_W-1:0]  keep_q;

  // result being built, and output register
  logic [ST_W-1:0]  res_st_q;
  logic [FD_W-1:0]  res_fd_q;
  logic [OBJ_W-1:0] res_hh_q;
  logic             res_hw_q;
  logic             res_rv_q;
  logic [OBJ_W-1:0] res_rh_q;
  logic             out_valid_q;
  logic [ST_W-1:0]  out_st_q;
  logic [FD_W-1:0]  out_fd_q;
  logic [OBJ_W-1:0] out_hh_q;
  logic             out_hw_q;
  logic             out_rv_q;
  logic [OBJ_W-1:0] out_rh_q;

  // memories
  logic [ROW_W-1:0]        row_mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] row_vld_q;
  logic [ROW_W-1:0]        row_rd_q;
  logic                    rd_vld_q;
  logic [OBJ_W:0]          slot_mem [TOTAL_SLOTS];
  logic [OBJ_W:0]          slot_rd_q;

  // combinational helpers
  logic                    tfd_ok, sfd_ok, floor_ok;
  logic [BASE_W-1:0]       base_nx;
  logic                    bkt_last;
  logic [IDX_W-1:0]        rel;
  logic [OFF_W-1:0]        off;
  logic [ROW_W-1:0]        rd_row;
  logic [SLOTS_PER_BUCKET-1:0] ev_bits;
  logic [FILL_W-1:0]       ev_fill;
  logic                    ev_full;
  logic                    cur_open;
  logic [SCN_W-1:0]        ev_pad;
  logic [SCN_W-1:0]        scan_init;
  logic [2:0]              pe;
  logic                    grp_free;
  logic [GRP_W+2:0]        pos;
  logic [IDX_W-1:0]        scan_idx;
  logic                    rd_en;
  logic                    row_we;
  logic [SLOTS_PER_BUCKET-1:0] wbits;
  logic [FILL_W-1:0]       wfill;
  logic                    slot_we;
  logic [IDX_W-1:0]        slot_waddr;

  assign in_ready_o = (state_q == S_IDLE);

  assign tfd_ok   = !tfd_q[FDI_W-1] && (int'(tfd_q) < TOTAL_SLOTS);
  assign sfd_ok   = !sfd_q[FDI_W-1] && (int'(sfd_q) < TOTAL_SLOTS);
  assign floor_ok = tfd_q[FDI_W-1] || tfd_ok;

  assign base_nx  = base_q + BASE_W'(SLOTS_PER_BUCKET);
  assign bkt_last = (bkt_q == BKT_W'(BUCKET_COUNT - 1));
  assign rel      = key_q - base_q[IDX_W-1:0];
  assign off      = OFF_W'(rel);

  // a row never written reads as all closed, fill zero
  assign rd_row   = rd_vld_q ? row_rd_q : '0;
  assign ev_bits  = rd_row[SLOTS_PER_BUCKET-1:0];
  assign ev_fill  = rd_row[ROW_W-1:SLOTS_PER_BUCKET];
  assign ev_full  = (ev_fill == FILL_W'(SLOTS_PER_BUCKET));
  assign cur_open = ev_bits[off];
  // pad bits past the bucket read as open
  assign ev_pad   = ~(SCN_W'(~ev_bits));

  always_comb begin
    for (int i = 0; i < SCN_W; i++) begin
      scan_init[i] = ev_pad[i] | (first_q && (i < int'(off)));
    end
  end

  // first free bit of the current 8-bit group
  always_comb begin
    pe = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!scan_q[i]) pe = 3'(i);
    end
  end

  assign grp_free = (scan_q[7:0] != 8'hFF);
  assign pos      = {grp_q, pe};
  assign scan_idx = base_q[IDX_W-1:0] + IDX_W'(pos);
  assign rd_en    = (state_q == S_RD);

  // memory write decisions
  always_comb begin
    row_we     = 1'b0;
    wbits      = ev_bits;
    wfill      = ev_fill;
    slot_we    = 1'b0;
    slot_waddr = key_q;
    case (state_q)
      S_EV: begin
        case (op_q)
          OP_CLOSE: begin
            if (cur_open) begin
              row_we     = 1'b1;
              wbits[off] = 1'b0;
              wfill      = ev_fill - FILL_W'(1);
            end
          end
          OP_PUT: begin
            if (!cur_open) begin
              row_we     = 1'b1;
              wbits[off] = 1'b1;
              wfill      = ev_fill + FILL_W'(1);
              slot_we    = 1'b1;
            end
          end
          OP_DUP2: begin
            // target phase: displacing an open slot keeps the count
            if (tgt_q) begin
              row_we     = 1'b1;
              wbits[off] = 1'b1;
              wfill      = cur_open ? ev_fill : ev_fill + FILL_W'(1);
              slot_we    = 1'b1;
            end
          end
          default: begin
            row_we = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        wbits = keep_q[SLOTS_PER_BUCKET-1:0];
        wfill = keep_q[ROW_W-1:SLOTS_PER_BUCKET] + FILL_W'(1);
        if (grp_free) begin
          row_we                   = 1'b1;
          wbits[OFF_W'(pos)]       = 1'b1;
          slot_we                  = 1'b1;
          slot_waddr               = scan_idx;
        end
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

  // bucket rows: fill count above open bitmap
  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[bkt_q] <= {wfill, wbits};
    if (rd_en)  row_rd_q       <= row_mem[bkt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (row_we) row_vld_q[bkt_q] <= 1'b1;
      if (rd_en)  rd_vld_q         <= row_vld_q[bkt_q];
    end
  end

  // slot contents: {writable, handle}
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= {wr_q, obj_q};
    if (rd_en)   slot_rd_q            <= slot_mem[key_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      op_q        <= '0;
      tfd_q       <= '0;
      sfd_q       <= '0;
      obj_q       <= '0;
      wr_q        <= 1'b0;
      key_q       <= '0;
      bkt_q       <= '0;
      base_q      <= '0;
      tgt_q       <= 1'b0;
      first_q     <= 1'b0;
      grp_q       <= '0;
      scan_q      <= '0;
      keep_q      <= '0;
      res_st_q    <= '0;
      res_fd_q    <= '0;
      res_hh_q    <= '0;
      res_hw_q    <= 1'b0;
      res_rv_q    <= 1'b0;
      res_rh_q    <= '0;
      out_st_q    <= '0;
      out_fd_q    <= '0;
      out_hh_q    <= '0;
      out_hw_q    <= 1'b0;
      out_rv_q    <= 1'b0;
      out_rh_q    <= '0;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= operation_i;
            tfd_q    <= target_fd_i;
            sfd_q    <= source_fd_i;
            obj_q    <= object_handle_i;
            wr_q     <= writable_in_i;
            res_st_q <= ST_BADFD;
            res_fd_q <= '0;
            res_hh_q <= '0;
            res_hw_q <= 1'b0;
            res_rv_q <= 1'b0;
            res_rh_q <= '0;
            state_q  <= S_DEC;
          end
        end

        S_DEC: begin
          bkt_q   <= '0;
          base_q  <= '0;
          tgt_q   <= 1'b0;
          first_q <= 1'b1;
          case (op_q)
            OP_ALLOC: begin
              if (floor_ok) begin
                key_q   <= tfd_q[FDI_W-1] ? '0 : IDX_W'(tfd_q);
                state_q <= S_POS;
              end else begin
                res_st_q <= ST_NOFREE;
                state_q  <= S_DONE;
              end
            end
            OP_CLOSE, OP_GET: begin
              if (tfd_ok) begin
                key_q   <= IDX_W'(tfd_q);
                state_q <= S_POS;
              end else begin
                state_q <= S_DONE;
              end
            end
            OP_PUT: begin
              if (tfd_ok && (obj_q != '0)) begin
                key_q   <= IDX_W'(tfd_q);
                state_q <= S_POS;
              end else begin
                res_st_q <= ST_NOTPLACED;
                state_q  <= S_DONE;
              end
            end
            OP_DUP2: begin
              if (tfd_ok && sfd_ok) begin
                key_q   <= IDX_W'(sfd_q);
                state_q <= S_POS;
              end else begin
                state_q <= S_DONE;
              end
            end
            default: begin
              res_st_q <= ST_BADFD;
              state_q  <= S_DONE;
            end
          endcase
        end

        // step one bucket per cycle until the key falls inside it
        S_POS: begin
          if ({1'b0, key_q} >= base_nx) begin
            bkt_q  <= bkt_q + BKT_W'(1);
            base_q <= base_nx;
          end else begin
            state_q <= S_RD;
          end
        end

        S_RD: begin
          state_q <= S_EV;
        end

        S_EV: begin
          case (op_q)
            OP_ALLOC: begin
              if (ev_full) begin
                if (bkt_last) begin
                  res_st_q <= ST_NOFREE;
                  state_q  <= S_DONE;
                end else begin
                  bkt_q   <= bkt_q + BKT_W'(1);
                  base_q  <= base_nx;
                  first_q <= 1'b0;
                  state_q <= S_RD;
                end
              end else begin
                scan_q  <= scan_init;
                keep_q  <= rd_row;
                grp_q   <= '0;
                state_q <= S_SCAN;
              end
            end
            OP_CLOSE: begin
              state_q <= S_DONE;
              if (cur_open) begin
                res_st_q <= ST_OK;
                res_fd_q <= FD_W'(key_q);
                res_rv_q <= 1'b1;
                res_rh_q <= slot_rd_q[OBJ_W-1:0];
              end
            end
            OP_PUT: begin
              state_q <= S_DONE;
              if (cur_open) begin
                res_st_q <= ST_NOTPLACED;
              end else begin
                res_st_q <= ST_OK;
                res_fd_q <= FD_W'(key_q);
                res_hh_q <= obj_q;
                res_hw_q <= wr_q;
              end
            end
            OP_GET: begin
              state_q <= S_DONE;
              if (cur_open) begin
                res_st_q <= ST_OK;
                res_fd_q <= FD_W'(key_q);
                res_hh_q <= slot_rd_q[OBJ_W-1:0];
                res_hw_q <= slot_rd_q[OBJ_W];
              end
            end
            OP_DUP2: begin
              if (!tgt_q) begin
                if (cur_open) begin
                  // carry the source contents over to the target phase
                  obj_q    <= slot_rd_q[OBJ_W-1:0];
                  wr_q     <= slot_rd_q[OBJ_W];
                  res_st_q <= ST_OK;
                  res_fd_q <= FD_W'(key_q);
                  res_hh_q <= slot_rd_q[OBJ_W-1:0];
                  res_hw_q <= slot_rd_q[OBJ_W];
                  if (sfd_q != tfd_q) begin
                    key_q   <= IDX_W'(tfd_q);
                    bkt_q   <= '0;
                    base_q  <= '0;
                    tgt_q   <= 1'b1;
                    state_q <= S_POS;
                  end else begin
                    state_q <= S_DONE;
                  end
                end else begin
                  state_q <= S_DONE;
                end
              end else begin
                res_fd_q <= FD_W'(key_q);
                res_rv_q <= cur_open;
                res_rh_q <= cur_open ? slot_rd_q[OBJ_W-1:0] : '0;
                state_q  <= S_DONE;
              end
            end
            default: begin
              res_st_q <= ST_BADFD;
              state_q  <= S_DONE;
            end
          endcase
        end

        // free-bit search, 8 slots per cycle
        S_SCAN: begin
          if (grp_free) begin
            res_st_q <= ST_OK;
            res_fd_q <= FD_W'(scan_idx);
            res_hh_q <= obj_q;
            res_hw_q <= wr_q;
            state_q  <= S_DONE;
          end else if (grp_q == GRP_W'(NGRP - 1)) begin
            if (bkt_last) begin
              res_st_q <= ST_NOFREE;
              state_q  <= S_DONE;
            end else begin
              bkt_q   <= bkt_q + BKT_W'(1);
              base_q  <= base_nx;
              first_q <= 1'b0;
              state_q <= S_RD;
            end
          end else begin
            grp_q  <= grp_q + GRP_W'(1);
            scan_q <= scan_q >> 8;
          end
        end

        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_st_q    <= res_st_q;
            out_fd_q    <= res_fd_q;
            out_hh_q    <= res_hh_q;
            out_hw_q    <= res_hw_q;
            out_rv_q    <= res_rv_q;
            out_rh_q    <= res_rh_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_st_q;
  assign result_fd_o       = out_fd_q;
  assign held_handle_o     = out_hh_q;
  assign held_writable_o   = out_hw_q;
  assign released_valid_o  = out_rv_q;
  assign released_handle_o = out_rh_q;

endmodule
